FILE: hw/rtl/obvp_pkg.sv
package obvp_pkg;

  localparam int unsigned FIELD_W = 18;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned COEF_W  = 20;  // signed operand A of the shared multiplier
  localparam int unsigned OPND_W  = 32;  // signed operand B
  localparam int unsigned PROD_W  = COEF_W + OPND_W;
  localparam int unsigned ACC_W   = 56;
  localparam int unsigned NUM_OPS = 26;
  localparam int unsigned OP_W    = 5;

  // Signed Q3.16 kinematic coefficients; angular estimate ones fold in 1/0.075
  localparam logic signed [COEF_W-1:0] C_RAD   = 20'sd27145;
  localparam logic signed [COEF_W-1:0] C_TAN02 = 20'sd22702;
  localparam logic signed [COEF_W-1:0] C_TAN13 = 20'sd18534;
  localparam logic signed [COEF_W-1:0] C_ANG02 = 20'sd255940;
  localparam logic signed [COEF_W-1:0] C_ANG13 = 20'sd180967;
  localparam logic signed [COEF_W-1:0] C_SIN60 = 20'sd56754;
  localparam logic signed [COEF_W-1:0] C_HALF  = 20'sd32768;
  localparam logic signed [COEF_W-1:0] C_SIN45 = 20'sd46334;
  localparam logic signed [COEF_W-1:0] C_ROT   = 20'sd4915;

  typedef enum logic [1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_I = 2'd1,
    REG_GAIN_D = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    A_CONST,
    A_GP,
    A_GI,
    A_GD
  } a_sel_e;

  typedef enum logic [3:0] {
    B_DR,
    B_D02,
    B_D13,
    B_S02,
    B_S13,
    B_ERR,
    B_SUM,
    B_DIFF,
    B_VR,
    B_VT,
    B_VW
  } b_sel_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_ACC  = 6'b000100,
    ST_FIN  = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  typedef struct packed {
    logic [3:0]               grp;
    logic [1:0]               axis;
    a_sel_e                   a_sel;
    logic signed [COEF_W-1:0] coef;
    b_sel_e                   b_sel;
    logic                     last;
  } op_t;

  // Groups: 0..2 body estimate, 3..5 PID per axis, 6..9 wheel setpoints
  function automatic op_t op_decode(input logic [OP_W-1:0] op);
    op_t o;
    o = '{grp: 4'd0, axis: 2'd0, a_sel: A_CONST, coef: '0, b_sel: B_DR, last: 1'b0};
    case (op)
      5'd0:  o = '{4'd0, 2'd0, A_CONST, C_RAD,    B_DR,   1'b1};
      5'd1:  o = '{4'd1, 2'd1, A_CONST, C_TAN02,  B_D02,  1'b0};
      5'd2:  o = '{4'd1, 2'd1, A_CONST, C_TAN13,  B_D13,  1'b1};
      5'd3:  o = '{4'd2, 2'd2, A_CONST, C_ANG02,  B_S02,  1'b0};
      5'd4:  o = '{4'd2, 2'd2, A_CONST, C_ANG13,  B_S13,  1'b1};
      5'd5:  o = '{4'd3, 2'd0, A_GP,    '0,       B_ERR,  1'b0};
      5'd6:  o = '{4'd3, 2'd0, A_GI,    '0,       B_SUM,  1'b0};
      5'd7:  o = '{4'd3, 2'd0, A_GD,    '0,       B_DIFF, 1'b1};
      5'd8:  o = '{4'd4, 2'd1, A_GP,    '0,       B_ERR,  1'b0};
      5'd9:  o = '{4'd4, 2'd1, A_GI,    '0,       B_SUM,  1'b0};
      5'd10: o = '{4'd4, 2'd1, A_GD,    '0,       B_DIFF, 1'b1};
      5'd11: o = '{4'd5, 2'd2, A_GP,    '0,       B_ERR,  1'b0};
      5'd12: o = '{4'd5, 2'd2, A_GI,    '0,       B_SUM,  1'b0};
      5'd13: o = '{4'd5, 2'd2, A_GD,    '0,       B_DIFF, 1'b1};
      5'd14: o = '{4'd6, 2'd0, A_CONST, C_SIN60,  B_VT,   1'b0};
      5'd15: o = '{4'd6, 2'd0, A_CONST, -C_HALF,  B_VR,   1'b0};
      5'd16: o = '{4'd6, 2'd0, A_CONST, C_ROT,    B_VW,   1'b1};
      5'd17: o = '{4'd7, 2'd1, A_CONST, C_SIN45,  B_VT,   1'b0};
      5'd18: o = '{4'd7, 2'd1, A_CONST, C_SIN45,  B_VR,   1'b0};
      5'd19: o = '{4'd7, 2'd1, A_CONST, C_ROT,    B_VW,   1'b1};
      5'd20: o = '{4'd8, 2'd2, A_CONST, -C_SIN60, B_VT,   1'b0};
      5'd21: o = '{4'd8, 2'd2, A_CONST, -C_HALF,  B_VR,   1'b0};
      5'd22: o = '{4'd8, 2'd2, A_CONST, C_ROT,    B_VW,   1'b1};
      5'd23: o = '{4'd9, 2'd3, A_CONST, -C_SIN45, B_VT,   1'b0};
      5'd24: o = '{4'd9, 2'd3, A_CONST, C_SIN45,  B_VR,   1'b0};
      5'd25: o = '{4'd9, 2'd3, A_CONST, C_ROT,    B_VW,   1'b1};
      default: o = '{4'd9, 2'd3, A_CONST, '0,     B_DR,   1'b1};
    endcase
    return o;
  endfunction

endpackage

FILE: hw/rtl/obvp_ram.sv
module obvp_ram #(
  parameter int unsigned WIDTH = 54,
  parameter int unsigned DEPTH = 20
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/omni_body_velocity_pid_top.sv
// Body-velocity PID for a four-wheel omni base, one control tick per beat.
// Slave stream: one beat carries the three body-velocity targets and the
// four measured wheel speeds (signed Q6.12). Master stream: one beat with
// the four saturated wheel setpoints (signed Q6.12). Gains are to be written
// on the cfg port (index 0 P, 1 I, 2 D; signed Q4.12) only while the block
// is idle; the block itself does not enforce this. A tick runs on one shared
// 20x32 multiplier with an accumulator: 26 multiply/accumulate ops, each a
// MUL and an ACC state, ten group finish states and one window update
// state, after which m_axis_tvalid rises in the OUT state; the next beat is
// taken only after the result beat leaves and the block is back in idle.
// s_axis_tready is high only while idle. If the receiver stalls the result
// holds on the master side and no new beat is taken. The error history sits
// in a WINDOW-deep RAM as a circular buffer with a running sum per axis; a
// fill counter masks entries not yet written, so reset only clears the
// counters, sums and previous errors and the block is ready right after
// reset. Gains reset to zero.
module omni_body_velocity_pid_top #(
  parameter int unsigned WINDOW = 20
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: target_radial, target_tangent, target_angular,
  //        measured_wheel_0..3, 2 pad bits
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: setpoint_wheel_0..3
  output logic [71:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_wdata_i
);

  localparam int unsigned FW    = obvp_pkg::FIELD_W;
  localparam int unsigned AW    = obvp_pkg::ACC_W;
  localparam int unsigned PTR_W = $clog2(WINDOW);
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W = FW + $clog2(WINDOW);
  localparam int unsigned VW    = obvp_pkg::OPND_W;

  localparam logic signed [AW-1:0] SAT_HI = AW'(131071);
  localparam logic signed [AW-1:0] SAT_LO = -AW'(131072);
  localparam logic signed [AW-1:0] RND16  = AW'(32768);
  localparam logic signed [AW-1:0] RND12  = AW'(2048);

  function automatic logic signed [FW-1:0] sat18(input logic signed [AW-1:0] v);
    logic signed [FW-1:0] r;
    if (v > SAT_HI) begin
      r = FW'(131071);
    end else if (v < SAT_LO) begin
      r = -FW'(131072);
    end else begin
      r = v[FW-1:0];
    end
    return r;
  endfunction

  obvp_pkg::state_e state_q, state_d;
  logic [obvp_pkg::OP_W-1:0] op_q;
  logic                      first_q;
  obvp_pkg::op_t             op;

  logic signed [obvp_pkg::GAIN_W-1:0] gp_q, gi_q, gd_q;
  logic signed [FW-1:0] tgt_q [3];
  logic signed [FW-1:0] meas_q [4];
  logic signed [FW-1:0] err_q [3];
  logic signed [FW-1:0] prev_q [3];
  logic signed [FW:0]   diff_q [3];
  logic signed [SUM_W-1:0] sum_q [3];
  logic signed [VW-1:0] vel_q [3];
  logic signed [FW-1:0] setp_q [4];

  logic [PTR_W-1:0] ptr_q;
  logic [CNT_W-1:0] fill_q;

  logic signed [obvp_pkg::COEF_W-1:0] opa;
  logic signed [VW-1:0]               opb;
  logic signed [obvp_pkg::PROD_W-1:0] prod_q;
  logic signed [AW-1:0]               acc_q;
  logic signed [AW-1:0]               est_w, pid_w;

  logic [3*FW-1:0] old_word;
  logic            old_valid;
  logic            in_beat, out_beat;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign op       = obvp_pkg::op_decode(op_q);

  // Operand select for the shared multiplier
  always_comb begin
    case (op.a_sel)
      obvp_pkg::A_GP: opa = obvp_pkg::COEF_W'(gp_q);
      obvp_pkg::A_GI: opa = obvp_pkg::COEF_W'(gi_q);
      obvp_pkg::A_GD: opa = obvp_pkg::COEF_W'(gd_q);
      default:        opa = op.coef;
    endcase
    case (op.b_sel)
      obvp_pkg::B_DR:   opb = VW'(-meas_q[0] + meas_q[1] - meas_q[2] + meas_q[3]);
      obvp_pkg::B_D02:  opb = VW'(meas_q[0] - meas_q[2]);
      obvp_pkg::B_D13:  opb = VW'(meas_q[1] - meas_q[3]);
      obvp_pkg::B_S02:  opb = VW'(meas_q[0] + meas_q[2]);
      obvp_pkg::B_S13:  opb = VW'(meas_q[1] + meas_q[3]);
      obvp_pkg::B_ERR:  opb = VW'(err_q[op.axis[1:0]]);
      obvp_pkg::B_SUM:  opb = VW'(sum_q[op.axis[1:0]]);
      obvp_pkg::B_DIFF: opb = VW'(diff_q[op.axis[1:0]]);
      obvp_pkg::B_VR:   opb = vel_q[0];
      obvp_pkg::B_VT:   opb = vel_q[1];
      obvp_pkg::B_VW:   opb = vel_q[2];
      default:          opb = '0;
    endcase
  end

  assign est_w = (acc_q + RND16) >>> 16;
  assign pid_w = (acc_q + RND12) >>> 12;

  always_comb begin
    state_d = state_q;
    case (state_q)
      obvp_pkg::ST_IDLE: if (in_beat) state_d = obvp_pkg::ST_MUL;
      obvp_pkg::ST_MUL:  state_d = obvp_pkg::ST_ACC;
      obvp_pkg::ST_ACC:  state_d = op.last ? obvp_pkg::ST_FIN : obvp_pkg::ST_MUL;
      obvp_pkg::ST_FIN: begin
        if (op.grp == 4'd2) begin
          state_d = obvp_pkg::ST_UPD;
        end else if (op.grp == 4'd9) begin
          state_d = obvp_pkg::ST_OUT;
        end else begin
          state_d = obvp_pkg::ST_MUL;
        end
      end
      obvp_pkg::ST_UPD:  state_d = obvp_pkg::ST_MUL;
      obvp_pkg::ST_OUT:  if (out_beat) state_d = obvp_pkg::ST_IDLE;
      default:           state_d = obvp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= obvp_pkg::ST_IDLE;
      op_q    <= '0;
      first_q <= 1'b1;
      gp_q    <= '0;
      gi_q    <= '0;
      gd_q    <= '0;
      ptr_q   <= '0;
      fill_q  <= '0;
      for (int a = 0; a < 3; a++) begin
        sum_q[a]  <= '0;
        prev_q[a] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          obvp_pkg::REG_GAIN_P: gp_q <= cfg_wdata_i;
          obvp_pkg::REG_GAIN_I: gi_q <= cfg_wdata_i;
          obvp_pkg::REG_GAIN_D: gd_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      case (state_q)
        obvp_pkg::ST_IDLE: begin
          op_q    <= '0;
          first_q <= 1'b1;
        end
        obvp_pkg::ST_ACC: begin
          first_q <= 1'b0;
          if (!op.last) op_q <= op_q + 1'b1;
        end
        obvp_pkg::ST_FIN: begin
          first_q <= 1'b1;
          op_q    <= op_q + 1'b1;
        end
        obvp_pkg::ST_UPD: begin
          for (int a = 0; a < 3; a++) begin
            sum_q[a] <= sum_q[a] + SUM_W'(err_q[a])
                        - (old_valid ? SUM_W'($signed(old_word[a*FW +: FW])) : '0);
            prev_q[a] <= err_q[a];
          end
          ptr_q <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
          if (fill_q != CNT_W'(WINDOW)) fill_q <= fill_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      for (int a = 0; a < 3; a++) tgt_q[a] <= s_axis_tdata[a*FW +: FW];
      for (int w = 0; w < 4; w++) meas_q[w] <= s_axis_tdata[(w+3)*FW +: FW];
    end
    if (state_q == obvp_pkg::ST_MUL) begin
      prod_q <= opa * opb;
    end
    if (state_q == obvp_pkg::ST_ACC) begin
      acc_q <= (first_q ? '0 : acc_q) + AW'(prod_q);
    end
    if (state_q == obvp_pkg::ST_FIN) begin
      if (op.grp < 4'd3) begin
        err_q[op.axis[1:0]] <= sat18(AW'(tgt_q[op.axis[1:0]]) - est_w);
      end else if (op.grp < 4'd6) begin
        vel_q[op.axis[1:0]] <= VW'(tgt_q[op.axis[1:0]]) + $signed(pid_w[VW-1:0]);
      end else begin
        setp_q[op.axis] <= sat18(est_w);
      end
    end
    if (state_q == obvp_pkg::ST_UPD) begin
      for (int a = 0; a < 3; a++) diff_q[a] <= (FW+1)'(err_q[a]) - (FW+1)'(prev_q[a]);
    end
  end

  assign old_valid = (fill_q == CNT_W'(WINDOW));

  obvp_ram #(
    .WIDTH(3 * FW),
    .DEPTH(WINDOW)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (state_q == obvp_pkg::ST_UPD),
    .waddr_i(ptr_q),
    .wdata_i({err_q[2], err_q[1], err_q[0]}),
    .re_i   (in_beat),
    .raddr_i(ptr_q),
    .rdata_o(old_word)
  );

  assign s_axis_tready = (state_q == obvp_pkg::ST_IDLE);
  assign m_axis_tvalid = (state_q == obvp_pkg::ST_OUT);
  assign m_axis_tdata  = {setp_q[3], setp_q[2], setp_q[1], setp_q[0]};

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result is pending");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(WINDOW))
    else $error("fill count past window depth");

  a_fill_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != CNT_W'(WINDOW)) |-> (CNT_W'(ptr_q) == fill_q))
    else $error("write pointer out of step with fill count");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == obvp_pkg::ST_MUL && op_q == '0 && first_q))
    else $error("tick did not start at first op");

  a_upd_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == obvp_pkg::ST_UPD) |=> (state_q == obvp_pkg::ST_MUL && $changed(ptr_q)))
    else $error("window update did not advance pointer");

endmodule
